/* rtl/hslp_pkg.sv */
// ----------------------------------------------------------------------------
// hslp_pkg: shared types, constants and helpers for the start line parser
// Character classes, decimal accumulation, recognizer phase codes and the
// report structs passed from the recognizers to the top level.
// ----------------------------------------------------------------------------
package hslp_pkg;

  localparam int MIN_LINE_BYTES_DEF = 14;
  localparam int ID_MAX_CHARS_DEF   = 8;

  localparam logic [63:0] PROTO_ID_RST  = 64'h0000_0000_5054_5448;  // "HTTP"
  localparam logic [3:0]  PROTO_LEN_RST = 4'd4;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  // configuration register indexes
  localparam logic CFG_PROTO_ID  = 1'b0;
  localparam logic CFG_PROTO_LEN = 1'b1;

  // byte roles
  localparam logic [1:0] ROLE_OTHER  = 2'd0;
  localparam logic [1:0] ROLE_METHOD = 2'd1;
  localparam logic [1:0] ROLE_URI    = 2'd2;
  localparam logic [1:0] ROLE_REASON = 2'd3;

  // verdicts
  localparam logic [1:0] VERDICT_INVALID = 2'd0;
  localparam logic [1:0] VERDICT_STATUS  = 2'd1;
  localparam logic [1:0] VERDICT_REQUEST = 2'd2;

  typedef enum logic [9:0] {
    SP_ID     = 10'b00_0000_0001,
    SP_SLASH  = 10'b00_0000_0010,
    SP_MAJ0   = 10'b00_0000_0100,
    SP_MAJ    = 10'b00_0000_1000,
    SP_MIN0   = 10'b00_0001_0000,
    SP_MIN    = 10'b00_0010_0000,
    SP_CODE   = 10'b00_0100_0000,
    SP_REASON = 10'b00_1000_0000,
    SP_DONE   = 10'b01_0000_0000,
    SP_FAIL   = 10'b10_0000_0000
  } st_phase_t;

  typedef enum logic [11:0] {
    RP_METH0 = 12'b0000_0000_0001,
    RP_METH  = 12'b0000_0000_0010,
    RP_URI0  = 12'b0000_0000_0100,
    RP_URI   = 12'b0000_0000_1000,
    RP_ID    = 12'b0000_0001_0000,
    RP_SLASH = 12'b0000_0010_0000,
    RP_MAJ0  = 12'b0000_0100_0000,
    RP_MAJ   = 12'b0000_1000_0000,
    RP_MIN0  = 12'b0001_0000_0000,
    RP_MIN   = 12'b0010_0000_0000,
    RP_DONE  = 12'b0100_0000_0000,
    RP_FAIL  = 12'b1000_0000_0000
  } rq_phase_t;

  // one byte step shared by both recognizers
  typedef struct packed {
    logic       en;
    logic [7:0] c;
    logic       last;
  } step_t;

  typedef struct packed {
    logic        ok;      // phase after this byte accepts a status line
    logic        reason;
    logic [15:0] major;
    logic [15:0] minor;
    logic [15:0] code;
  } st_rep_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  role;
    logic [15:0] major;
    logic [15:0] minor;
  } rq_rep_t;

  function automatic logic is_ctl(input logic [7:0] c);
    return (c < 8'd32) || (c == CH_DEL);
  endfunction

  function automatic logic is_decimal(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_method_char(input logic [7:0] c);
    logic ok;
    ok = !c[7] && !is_ctl(c) && (c != CH_SPACE) && (c != CH_TAB);
    case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c,
      8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d: ok = 1'b0;
      default: ;
    endcase
    return ok;
  endfunction

  // acc * 10 + digit, saturating at 16 bits
  function automatic logic [15:0] acc10(input logic [15:0] acc, input logic [7:0] c);
    logic [19:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, c[3:0]};
    return (v > 20'd65535) ? 16'hffff : v[15:0];
  endfunction

  function automatic logic [7:0] id_char(input logic [63:0] id, input logic [2:0] idx);
    return id[{idx, 3'b000} +: 8];
  endfunction

endpackage

/* rtl/hslp_status_rec.sv */
// ----------------------------------------------------------------------------
// hslp_status_rec: status line recognizer
// Tracks ID '/' major '.' minor ' ' code ' ' reason, one byte per step.
// ----------------------------------------------------------------------------
module hslp_status_rec #(
  parameter int MIN_LINE_BYTES = hslp_pkg::MIN_LINE_BYTES_DEF,
  parameter int ID_MAX_CHARS   = hslp_pkg::ID_MAX_CHARS_DEF,
  localparam int CNT_MAX = (MIN_LINE_BYTES > ID_MAX_CHARS) ? MIN_LINE_BYTES : ID_MAX_CHARS,
  localparam int CNT_W   = $clog2(CNT_MAX + 1),
  localparam int LEN_W   = $clog2(ID_MAX_CHARS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  hslp_pkg::step_t       step,
  input  logic [63:0]           proto_id,
  input  logic [LEN_W-1:0]      id_len,
  input  logic [CNT_W-1:0]      line_count,
  output hslp_pkg::st_rep_t     rep
);
  import hslp_pkg::*;

  st_phase_t   phase, phase_next, p;
  logic [15:0] major, major_next;
  logic [15:0] minor, minor_next;
  logic [15:0] code, code_next;
  logic        reason;
  logic [CNT_W:0] count_inc;

  assign count_inc = {1'b0, line_count} + 1'b1;

  always_comb begin
    p          = phase;
    major_next = major;
    minor_next = minor;
    code_next  = code;
    reason     = 1'b0;
    if (p == SP_ID && line_count >= CNT_W'(id_len)) p = SP_SLASH;
    case (p)
      SP_ID: begin
        if (step.c != id_char(proto_id, 3'(line_count))) p = SP_FAIL;
        else if (count_inc >= (CNT_W+1)'(id_len)) p = SP_SLASH;
      end
      SP_SLASH: p = (step.c == CH_SLASH) ? SP_MAJ0 : SP_FAIL;
      SP_MAJ0, SP_MAJ: begin
        if (is_decimal(step.c)) begin
          major_next = acc10((p == SP_MAJ0) ? 16'd0 : major, step.c);
          p = SP_MAJ;
        end else begin
          p = (p == SP_MAJ && step.c == CH_DOT) ? SP_MIN0 : SP_FAIL;
        end
      end
      SP_MIN0, SP_MIN: begin
        if (is_decimal(step.c)) begin
          minor_next = acc10((p == SP_MIN0) ? 16'd0 : minor, step.c);
          p = SP_MIN;
        end else begin
          p = (p == SP_MIN && step.c == CH_SPACE) ? SP_CODE : SP_FAIL;
        end
      end
      SP_CODE: begin
        if (is_decimal(step.c)) code_next = acc10(code, step.c);
        else p = (step.c == CH_SPACE) ? SP_REASON : SP_FAIL;
      end
      SP_REASON: begin
        if (is_ctl(step.c)) p = SP_DONE;
        else reason = 1'b1;
      end
      SP_DONE: ;
      default: p = SP_FAIL;
    endcase
    phase_next = p;
  end

  assign rep.ok     = (phase_next == SP_REASON) || (phase_next == SP_DONE);
  assign rep.reason = reason;
  assign rep.major  = major_next;
  assign rep.minor  = minor_next;
  assign rep.code   = code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= SP_ID;
      major <= '0;
      minor <= '0;
      code  <= '0;
    end else if (step.en) begin
      if (step.last) begin
        phase <= SP_ID;
        major <= '0;
        minor <= '0;
        code  <= '0;
      end else begin
        phase <= phase_next;
        major <= major_next;
        minor <= minor_next;
        code  <= code_next;
      end
    end
  end

endmodule

/* rtl/hslp_request_rec.sv */
// ----------------------------------------------------------------------------
// hslp_request_rec: request line recognizer
// Tracks method ' ' URI ' ' ID '/' major '.' minor, one byte per step.
// ----------------------------------------------------------------------------
module hslp_request_rec #(
  parameter int ID_MAX_CHARS = hslp_pkg::ID_MAX_CHARS_DEF,
  localparam int LEN_W = $clog2(ID_MAX_CHARS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  hslp_pkg::step_t       step,
  input  logic [63:0]           proto_id,
  input  logic [LEN_W-1:0]      id_len,
  output hslp_pkg::rq_rep_t     rep
);
  import hslp_pkg::*;

  rq_phase_t        phase, phase_next, p;
  logic [LEN_W-1:0] id_index, id_index_next;
  logic [15:0]      major, major_next;
  logic [15:0]      minor, minor_next;
  logic [1:0]       role;
  logic [LEN_W:0]   index_inc;

  assign index_inc = {1'b0, id_index} + 1'b1;

  always_comb begin
    p             = phase;
    id_index_next = id_index;
    major_next    = major;
    minor_next    = minor;
    role          = ROLE_OTHER;
    if (p == RP_ID && id_index >= id_len) p = RP_SLASH;
    case (p)
      RP_METH0, RP_METH: begin
        if (is_method_char(step.c)) begin
          p    = RP_METH;
          role = ROLE_METHOD;
        end else begin
          p = (p == RP_METH && step.c == CH_SPACE) ? RP_URI0 : RP_FAIL;
        end
      end
      RP_URI0, RP_URI: begin
        if (!is_ctl(step.c) && step.c != CH_SPACE) begin
          p    = RP_URI;
          role = ROLE_URI;
        end else if (p == RP_URI && step.c == CH_SPACE) begin
          id_index_next = '0;
          p = (id_len == '0) ? RP_SLASH : RP_ID;
        end else begin
          p = RP_FAIL;
        end
      end
      RP_ID: begin
        if (step.c != id_char(proto_id, 3'(id_index))) begin
          p = RP_FAIL;
        end else begin
          id_index_next = index_inc[LEN_W-1:0];
          if (index_inc >= {1'b0, id_len}) p = RP_SLASH;
        end
      end
      RP_SLASH: p = (step.c == CH_SLASH) ? RP_MAJ0 : RP_FAIL;
      RP_MAJ0, RP_MAJ: begin
        if (is_decimal(step.c)) begin
          major_next = acc10((p == RP_MAJ0) ? 16'd0 : major, step.c);
          p = RP_MAJ;
        end else begin
          p = (p == RP_MAJ && step.c == CH_DOT) ? RP_MIN0 : RP_FAIL;
        end
      end
      RP_MIN0, RP_MIN: begin
        if (is_decimal(step.c)) begin
          minor_next = acc10((p == RP_MIN0) ? 16'd0 : minor, step.c);
          p = RP_MIN;
        end else begin
          p = (p == RP_MIN) ? RP_DONE : RP_FAIL;
        end
      end
      RP_DONE: ;
      default: p = RP_FAIL;
    endcase
    phase_next = p;
  end

  assign rep.ok    = (phase_next == RP_MIN) || (phase_next == RP_DONE);
  assign rep.role  = role;
  assign rep.major = major_next;
  assign rep.minor = minor_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= RP_METH0;
      id_index <= '0;
      major    <= '0;
      minor    <= '0;
    end else if (step.en) begin
      if (step.last) begin
        phase    <= RP_METH0;
        id_index <= '0;
        major    <= '0;
        minor    <= '0;
      end else begin
        phase    <= phase_next;
        id_index <= id_index_next;
        major    <= major_next;
        minor    <= minor_next;
      end
    end
  end

endmodule

/* rtl/http_start_line_parser_top.sv */
// ----------------------------------------------------------------------------
// http_start_line_parser_top: HTTP start line recognizer, one byte per word
// Input register, status and request recognizers, verdict and result register.
// ----------------------------------------------------------------------------
// One byte word is taken in every cycle while the result side does not stall,
// and one result word leaves for each: the byte is captured in an input register,
// both recognizers and the decimal accumulators work on it combinationally, and
// the result register holds the tagged echo and, on the tlast word, the verdict.
// The input side keeps taking words while a result waits, as long as the
// input register can move on. A line ends at tlast, and its last byte is parsed
// like the others. Lines shorter than MIN_LINE_BYTES are reported invalid, and
// version numbers and the status code saturate at 65535.
module http_start_line_parser_top #(
  parameter int MIN_LINE_BYTES = hslp_pkg::MIN_LINE_BYTES_DEF,
  parameter int ID_MAX_CHARS   = hslp_pkg::ID_MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  // input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] line_byte
  input  logic        s_tlast,    // line_last
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,    // [7:0] echo_byte, [9:8] verdict, [25:10] ver_major,
                                  // [41:26] ver_minor, [57:42] status_code, rest zero
  output logic [1:0]  m_tuser,    // [1:0] byte_role
  output logic        m_tlast     // line_done
);
  import hslp_pkg::*;

  localparam int CNT_MAX = (MIN_LINE_BYTES > ID_MAX_CHARS) ? MIN_LINE_BYTES : ID_MAX_CHARS;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int LEN_W   = $clog2(ID_MAX_CHARS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ID_MAX_CHARS);
  localparam logic [LEN_W-1:0] LEN_RST =
    (PROTO_LEN_RST > 4'(ID_MAX_CHARS)) ? LEN_MAX : LEN_W'(PROTO_LEN_RST);

  // configuration
  logic [63:0]      proto_id;
  logic [LEN_W-1:0] id_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      proto_id <= PROTO_ID_RST;
      id_len   <= LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROTO_ID:  proto_id <= cfg_data;
        CFG_PROTO_LEN: id_len <= (cfg_data[3:0] > 4'(ID_MAX_CHARS)) ? LEN_MAX
                                                                    : LEN_W'(cfg_data[3:0]);
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       advance;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  // byte count of the current line, saturating
  logic [CNT_W-1:0] line_count, count_next;

  assign count_next = (line_count == CNT_W'(CNT_MAX)) ? line_count : line_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
    end else if (advance) begin
      line_count <= s1_last ? '0 : count_next;
    end
  end

  step_t   step;
  st_rep_t st_rep;
  rq_rep_t rq_rep;

  assign step.en   = advance;
  assign step.c    = s1_byte;
  assign step.last = s1_last;

  hslp_status_rec #(
    .MIN_LINE_BYTES (MIN_LINE_BYTES),
    .ID_MAX_CHARS   (ID_MAX_CHARS)
  ) u_status (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .proto_id   (proto_id),
    .id_len     (id_len),
    .line_count (line_count),
    .rep        (st_rep)
  );

  hslp_request_rec #(
    .ID_MAX_CHARS (ID_MAX_CHARS)
  ) u_request (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .proto_id (proto_id),
    .id_len   (id_len),
    .rep      (rq_rep)
  );

  // verdict
  logic        len_ok;
  logic [1:0]  role_next, verdict_next;
  logic [15:0] major_sel, minor_sel, code_sel;

  assign len_ok    = count_next >= CNT_W'(MIN_LINE_BYTES);
  assign role_next = st_rep.reason ? ROLE_REASON : rq_rep.role;

  always_comb begin
    verdict_next = VERDICT_INVALID;
    major_sel    = '0;
    minor_sel    = '0;
    code_sel     = '0;
    if (s1_last && len_ok && st_rep.ok) begin
      verdict_next = VERDICT_STATUS;
      major_sel    = st_rep.major;
      minor_sel    = st_rep.minor;
      code_sel     = st_rep.code;
    end else if (s1_last && len_ok && rq_rep.ok) begin
      verdict_next = VERDICT_REQUEST;
      major_sel    = rq_rep.major;
      minor_sel    = rq_rep.minor;
    end
  end

  // result register
  logic [7:0]  out_byte;
  logic [1:0]  out_role, out_verdict;
  logic        out_done;
  logic [15:0] out_major, out_minor, out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= s1_byte;
      out_role    <= role_next;
      out_done    <= s1_last;
      out_verdict <= verdict_next;
      out_major   <= major_sel;
      out_minor   <= minor_sel;
      out_code    <= code_sel;
    end
  end

  assign m_tdata = {6'd0, out_code, out_minor, out_major, out_verdict, out_byte};
  assign m_tuser = out_role;
  assign m_tlast = out_done;

  a_mid_line_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_done |-> out_verdict == VERDICT_INVALID && out_major == 16'd0 &&
                              out_minor == 16'd0 && out_code == 16'd0)
    else $error("verdict fields set on a word that does not end a line");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_verdict == VERDICT_INVALID |->
      out_major == 16'd0 && out_minor == 16'd0 && out_code == 16'd0)
    else $error("invalid line carries version or code");

  a_request_no_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_verdict == VERDICT_REQUEST |-> out_code == 16'd0)
    else $error("request line carries a status code");

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> line_count == '0)
    else $error("byte count not cleared after end of line");

endmodule
